// File: rtl/bounded_deque_with_search_assert.svh
// ----------------------------------------------------------------------------
// bounded_deque_with_search_assert.svh
// assertion macros for the deque top level, clocked on clk, reset by rst_n
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH

// same-cycle implication
`define BDQ_CHECK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDQ_CHECK_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// types, codes and ring helpers for the bounded deque with search
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int LEN_W  = 5;

  // command queue between front and back, power of two deep
  localparam int QD     = 2;
  localparam int QPTR_W = $clog2(QD);
  localparam int QCNT_W = $clog2(QD + 1);

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    CLS_PUSH_FRONT,
    CLS_PUSH_BACK,
    CLS_POP_FRONT,
    CLS_POP_BACK,
    CLS_SEARCH,
    CLS_NOP
  } bdq_cls_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP_RD,
    BK_SCAN
  } bdq_bk_state_t;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;
  } bdq_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] popped_value;
    logic                    found;
    logic [ST_W-1:0]         status;
    logic [LEN_W-1:0]        length;
  } bdq_out_t;

  typedef struct packed {
    bdq_cls_t                cls;
    logic signed [VAL_W-1:0] value;
  } bdq_cmd_t;

  // ring position offs places after base, both below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] offs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // ring position just before base
  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] base);
    return (base == '0) ? IDX_W'(DEPTH - 1) : base - IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

// File: rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/bdq_front.sv
// ----------------------------------------------------------------------------
// bdq_front
// takes command beats, classifies the operation code, queues the commands
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_front import bdq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire bdq_in_t  in_item,
  output logic          q_valid,
  output bdq_cmd_t      q_head,
  input  wire logic     q_pop
);

  bdq_cmd_t            q_mem_r [QD];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push;
  bdq_cmd_t            cmd_in;

  // decode
  always_comb begin
    cmd_in.value = in_item.value;
    unique case (in_item.operation)
      OP_PUSH_FRONT: cmd_in.cls = CLS_PUSH_FRONT;
      OP_PUSH_BACK:  cmd_in.cls = CLS_PUSH_BACK;
      OP_POP_FRONT:  cmd_in.cls = CLS_POP_FRONT;
      OP_POP_BACK:   cmd_in.cls = CLS_POP_BACK;
      OP_SEARCH:     cmd_in.cls = CLS_SEARCH;
      default:       cmd_in.cls = CLS_NOP;
    endcase
  end

  assign busy    = (cnt_r == QCNT_W'(QD));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_head  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bdq_back.sv
// ----------------------------------------------------------------------------
// bdq_back
// executes queued commands against the ring store and registers results
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_back import bdq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire bdq_cmd_t q_head,
  output logic          q_pop,
  output logic          out_strobe,
  output bdq_out_t      out_item
);

  bdq_bk_state_t     state_r, state_nxt;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  bdq_cmd_t          cmd_r, cmd_nxt;
  logic              out_valid_r, out_valid_nxt;
  bdq_out_t          out_r, out_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  logic              full;
  logic              empty;
  logic              match;
  logic              scan_last;
  logic [CNT_W-1:0]  cnt_m1;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign match     = (ram_rdata == cmd_r.value);
  assign scan_last = (iss_r == count_r);
  assign cnt_m1    = count_r - CNT_W'(1);

  bdq_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_head.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_head.cls) inside
            CLS_POP_FRONT, CLS_POP_BACK: state_nxt = empty ? BK_IDLE : BK_POP_RD;
            CLS_SEARCH:                  state_nxt = empty ? BK_IDLE : BK_SCAN;
            default:                     state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_POP_RD: state_nxt = BK_IDLE;
      BK_SCAN: begin
        if (match || scan_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    front_nxt     = front_r;
    count_nxt     = count_r;
    iss_nxt       = iss_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = front_r;
    ram_raddr     = front_r;

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop                = 1'b1;
          cmd_nxt              = q_head;
          out_nxt.popped_value = '0;
          out_nxt.found        = 1'b0;
          out_nxt.status       = ST_OK;
          unique case (q_head.cls)
            CLS_PUSH_FRONT: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_nxt.status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_prev(front_r);
                front_nxt = ring_prev(front_r);
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CLS_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_nxt.status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_add(front_r, count_r[IDX_W-1:0]);
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CLS_POP_FRONT: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_EMPTY;
              end
            end
            CLS_POP_BACK: begin
              ram_raddr = ring_add(front_r, cnt_m1[IDX_W-1:0]);
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = ST_EMPTY;
              end
            end
            CLS_SEARCH: begin
              iss_nxt = CNT_W'(1);
              if (empty) begin
                out_valid_nxt = 1'b1;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      BK_POP_RD: begin
        out_valid_nxt        = 1'b1;
        out_nxt.popped_value = ram_rdata;
        count_nxt            = cnt_m1;
        if (cmd_r.cls == CLS_POP_FRONT) begin
          front_nxt = ring_add(front_r, IDX_W'(1));
        end
      end
      BK_SCAN: begin
        if (match || scan_last) begin
          out_valid_nxt = 1'b1;
          out_nxt.found = match;
        end else begin
          ram_raddr = ring_add(front_r, iss_r[IDX_W-1:0]);
          iss_nxt   = iss_r + CNT_W'(1);
        end
      end
      default: ;
    endcase

    out_nxt.length = LEN_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r <= iss_nxt;
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

endmodule

`default_nettype wire

// File: rtl/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// bounded double-ended queue of signed words with a linear membership search
// ----------------------------------------------------------------------------
// usage
//   command beat: drive in_item (operation, value) with start high; the beat
//   is taken at a clock edge where start is high and busy is low. busy rises
//   when the two-entry command queue is full.
//   result beat: out_strobe is high for exactly one cycle with out_item
//   (popped_value, found, status, length); one result per command, in order.
//   the receiver cannot stall, so results are never held back.
// back end work per command (queue in between)
//   push, bad opcode, refused pop, search on empty: done in the idle state
//   pop: a read state follows, for the registered read of the ring store
//   search: one stored word compared per cycle on the single store read
//   port, up to length words; the back end takes no new command meanwhile
//   a push beat is registered in the command queue, then in the result register
// reset
//   rst_n is synchronous, active low: queue empty, deque empty, front at 0;
//   the store contents are not cleared, only live words are ever read
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_deque_with_search_assert.svh"

module bounded_deque_with_search import bdq_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire bdq_in_t in_item,
  output logic         out_strobe,
  output bdq_out_t     out_item
);

  // command queue head from the front end
  logic     q_valid;
  bdq_cmd_t q_head;
  logic     q_pop;

  // front end: decode the opcode and queue the command
  bdq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  // back end: ring store, front index, count, search scan, result register
  bdq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // result beat classification for the checks below
  logic rsp_full;
  logic rsp_empty;
  logic rsp_cleared;

  assign rsp_full    = out_strobe && (out_item.status == ST_FULL);
  assign rsp_empty   = out_strobe && (out_item.status == ST_EMPTY);
  assign rsp_cleared = (out_item.length == '0) && (out_item.popped_value == '0);

  // length never passes the capacity
  `BDQ_CHECK_IMP(a_len_bound, out_strobe, out_item.length <= LEN_W'(DEPTH), "length beyond depth")

  // a refused push only happens on a full deque
  `BDQ_CHECK_IMP(a_full_len, rsp_full, out_item.length == LEN_W'(DEPTH), "full status, room left")

  // a refused pop leaves an empty deque and returns zero
  `BDQ_CHECK_IMP(a_empty_pop, rsp_empty, rsp_cleared, "empty status on nonempty deque")

  // a full command queue stays full until the back end takes a command
  `BDQ_CHECK_NXT(a_busy_hold, busy && !q_pop, busy, "busy dropped without a dequeue")

endmodule

`default_nettype wire
